[hw/rtl/cmb_pkg.sv]
// ----------------------------------------------------------------------------
// cmb_pkg: shared types and helpers for the color matrix blend pipeline
// Pixel layout, register map, configuration bundle and the divide-by-255
// helper used by the mapping stages.
// ----------------------------------------------------------------------------
package cmb_pkg;

	localparam int CH_W      = 8;
	localparam int NUM_COLOR = 3;
	localparam int WGT_W     = 24;
	localparam int STR_W     = 9;
	localparam int PROD_W    = 16;
	localparam int SUM_W     = 18;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;

	// channel positions inside a pixel word, lowest byte first
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int CH_ALPHA = 3;

	localparam logic [WGT_W-1:0] RED_W_RESET   = 24'h0000FF;
	localparam logic [WGT_W-1:0] GREEN_W_RESET = 24'h00FF00;
	localparam logic [WGT_W-1:0] BLUE_W_RESET  = 24'hFF0000;
	localparam logic [STR_W-1:0] STR_RESET     = 9'd0;
	localparam logic [STR_W-1:0] STRENGTH_ONE  = 9'd256;
	localparam logic [CH_W-1:0]  CH_MAX        = 8'd255;

	typedef enum logic [1:0] {
		REG_RED_W   = 2'd0,
		REG_GREEN_W = 2'd1,
		REG_BLUE_W  = 2'd2,
		REG_STRENGTH = 2'd3
	} reg_idx_t;

	typedef logic [3:0][CH_W-1:0] pix_t;

	typedef struct packed {
		logic [WGT_W-1:0] red_w;
		logic [WGT_W-1:0] green_w;
		logic [WGT_W-1:0] blue_w;
		logic [STR_W-1:0] strength;
	} cfg_t;

	typedef struct packed {
		pix_t                             src;
		logic [NUM_COLOR-1:0][CH_W-1:0]   mapped;
	} map_t;

	// floor(x / 255) clamped to 255, exact for x < 2^18.
	// x = 256a + b gives x/255 = a + (a+b)/255; the same split once more
	// leaves a single compare against 255.
	function automatic logic [CH_W-1:0] div255_clamp(input logic [SUM_W-1:0] x);
		logic [9:0]  a;
		logic [10:0] t;
		logic [2:0]  c;
		logic [8:0]  cd;
		logic [10:0] q;
		a  = x[17:8];
		t  = 11'(a) + 11'(x[7:0]);
		c  = t[10:8];
		cd = 9'(c) + 9'(t[7:0]);
		q  = 11'(a) + 11'(c) + ((cd >= 9'(CH_MAX)) ? 11'd1 : 11'd0);
		div255_clamp = (q > 11'(CH_MAX)) ? CH_MAX : q[CH_W-1:0];
	endfunction

endpackage

[hw/rtl/cmb_regs.sv]
// ----------------------------------------------------------------------------
// cmb_regs: configuration register file
// APB-style write/read access to the weight and blend strength registers.
// ----------------------------------------------------------------------------
module cmb_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cmb_pkg::ADDR_W-1:0]   paddr,
	input  logic [cmb_pkg::DATA_W-1:0]   pwdata,
	output logic [cmb_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output cmb_pkg::cfg_t                cfg
);

	cmb_pkg::cfg_t     cfg_q;
	cmb_pkg::reg_idx_t idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign idx    = cmb_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.red_w    <= cmb_pkg::RED_W_RESET;
			cfg_q.green_w  <= cmb_pkg::GREEN_W_RESET;
			cfg_q.blue_w   <= cmb_pkg::BLUE_W_RESET;
			cfg_q.strength <= cmb_pkg::STR_RESET;
		end else if (wr_en) begin
			case (idx)
				cmb_pkg::REG_RED_W:    cfg_q.red_w    <= pwdata[cmb_pkg::WGT_W-1:0];
				cmb_pkg::REG_GREEN_W:  cfg_q.green_w  <= pwdata[cmb_pkg::WGT_W-1:0];
				cmb_pkg::REG_BLUE_W:   cfg_q.blue_w   <= pwdata[cmb_pkg::WGT_W-1:0];
				cmb_pkg::REG_STRENGTH: cfg_q.strength <= pwdata[cmb_pkg::STR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			cmb_pkg::REG_RED_W:    prdata = cmb_pkg::DATA_W'(cfg_q.red_w);
			cmb_pkg::REG_GREEN_W:  prdata = cmb_pkg::DATA_W'(cfg_q.green_w);
			cmb_pkg::REG_BLUE_W:   prdata = cmb_pkg::DATA_W'(cfg_q.blue_w);
			cmb_pkg::REG_STRENGTH: prdata = cmb_pkg::DATA_W'(cfg_q.strength);
			default:               prdata = '0;
		endcase
	end

endmodule

[hw/rtl/cmb_map.sv]
// ----------------------------------------------------------------------------
// cmb_map: color matrix stages
// Three stages: weight products, per-lane sums, divide by 255 with clamp.
// ----------------------------------------------------------------------------
module cmb_map (
	input  logic           clk,
	input  logic           arst_n,
	input  cmb_pkg::cfg_t  cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  cmb_pkg::pix_t  in_pix,
	output logic           out_valid,
	input  logic           out_ready,
	output cmb_pkg::map_t  out_map
);

	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;

	cmb_pkg::pix_t pix_s1, pix_s2, pix_s3;
	logic [cmb_pkg::NUM_COLOR-1:0][cmb_pkg::NUM_COLOR-1:0][cmb_pkg::PROD_W-1:0] prod_d, prod_s1;
	logic [cmb_pkg::NUM_COLOR-1:0][cmb_pkg::SUM_W-1:0] sum_d, sum_s2;
	logic [cmb_pkg::NUM_COLOR-1:0][cmb_pkg::CH_W-1:0]  map_d, map_s3;

	// a stage moves when its successor is empty or moving
	assign adv3     = !v_s3 || out_ready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	// lane l of each weight register feeds output channel l
	always_comb begin
		for (int l = 0; l < cmb_pkg::NUM_COLOR; l++) begin
			prod_d[l][cmb_pkg::CH_RED] =
				cmb_pkg::PROD_W'(in_pix[cmb_pkg::CH_RED]) *
				cmb_pkg::PROD_W'(cfg.red_w[l*cmb_pkg::CH_W +: cmb_pkg::CH_W]);
			prod_d[l][cmb_pkg::CH_GREEN] =
				cmb_pkg::PROD_W'(in_pix[cmb_pkg::CH_GREEN]) *
				cmb_pkg::PROD_W'(cfg.green_w[l*cmb_pkg::CH_W +: cmb_pkg::CH_W]);
			prod_d[l][cmb_pkg::CH_BLUE] =
				cmb_pkg::PROD_W'(in_pix[cmb_pkg::CH_BLUE]) *
				cmb_pkg::PROD_W'(cfg.blue_w[l*cmb_pkg::CH_W +: cmb_pkg::CH_W]);
		end
	end

	always_comb begin
		for (int l = 0; l < cmb_pkg::NUM_COLOR; l++) begin
			sum_d[l] = cmb_pkg::SUM_W'(prod_s1[l][cmb_pkg::CH_RED])
			         + cmb_pkg::SUM_W'(prod_s1[l][cmb_pkg::CH_GREEN])
			         + cmb_pkg::SUM_W'(prod_s1[l][cmb_pkg::CH_BLUE]);
		end
	end

	always_comb begin
		for (int l = 0; l < cmb_pkg::NUM_COLOR; l++) begin
			map_d[l] = cmb_pkg::div255_clamp(sum_s2[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			pix_s1  <= in_pix;
			prod_s1 <= prod_d;
		end
		if (adv2 && v_s1) begin
			pix_s2 <= pix_s1;
			sum_s2 <= sum_d;
		end
		if (adv3 && v_s2) begin
			pix_s3 <= pix_s2;
			map_s3 <= map_d;
		end
	end

	assign out_valid      = v_s3;
	assign out_map.src    = pix_s3;
	assign out_map.mapped = map_s3;

endmodule

[hw/rtl/cmb_blend.sv]
// ----------------------------------------------------------------------------
// cmb_blend: blend stages
// Two stages: scaled magnitude of (mapped - src), then the signed step
// toward the mapped value. Truncation is on the magnitude, i.e. toward zero.
// ----------------------------------------------------------------------------
module cmb_blend (
	input  logic           clk,
	input  logic           arst_n,
	input  cmb_pkg::cfg_t  cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  cmb_pkg::map_t  in_map,
	output logic           out_valid,
	input  logic           out_ready,
	output cmb_pkg::pix_t  out_pix
);

	logic v_s4, v_s5;
	logic adv4, adv5;
	logic [cmb_pkg::STR_W-1:0] str_sat;

	cmb_pkg::pix_t pix_s4, pix_d, pix_s5;
	logic [cmb_pkg::NUM_COLOR-1:0]                    up_d, up_s4;
	logic [cmb_pkg::NUM_COLOR-1:0][cmb_pkg::PROD_W-1:0] mag_d, mag_s4;
	logic [cmb_pkg::NUM_COLOR-1:0][cmb_pkg::CH_W-1:0]   diff;
	logic [cmb_pkg::NUM_COLOR-1:0][cmb_pkg::PROD_W:0]   mag_full;
	logic [cmb_pkg::NUM_COLOR-1:0][cmb_pkg::CH_W-1:0]   step;

	assign adv5     = !v_s5 || out_ready;
	assign adv4     = !v_s4 || adv5;
	assign in_ready = adv4;

	// strengths above one saturate to full mapping
	assign str_sat = (cfg.strength > cmb_pkg::STRENGTH_ONE) ? cmb_pkg::STRENGTH_ONE
	                                                        : cfg.strength;

	always_comb begin
		for (int l = 0; l < cmb_pkg::NUM_COLOR; l++) begin
			up_d[l]     = in_map.mapped[l] >= in_map.src[l];
			diff[l]     = up_d[l] ? (in_map.mapped[l] - in_map.src[l])
			                      : (in_map.src[l] - in_map.mapped[l]);
			mag_full[l] = (cmb_pkg::PROD_W+1)'(diff[l]) * (cmb_pkg::PROD_W+1)'(str_sat);
			// at most 255 * 256, fits the narrower register
			mag_d[l]    = mag_full[l][cmb_pkg::PROD_W-1:0];
		end
	end

	always_comb begin
		pix_d = pix_s4;
		for (int l = 0; l < cmb_pkg::NUM_COLOR; l++) begin
			step[l]  = mag_s4[l][cmb_pkg::PROD_W-1:cmb_pkg::CH_W];
			pix_d[l] = up_s4[l] ? (pix_s4[l] + step[l]) : (pix_s4[l] - step[l]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv4) v_s4 <= in_valid;
			if (adv5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4 && in_valid) begin
			pix_s4 <= in_map.src;
			up_s4  <= up_d;
			mag_s4 <= mag_d;
		end
		if (adv5 && v_s4) begin
			pix_s5 <= pix_d;
		end
	end

	assign out_valid = v_s5;
	assign out_pix   = pix_s5;

endmodule

[hw/rtl/color_matrix_blend_pixel.sv]
// ----------------------------------------------------------------------------
// color_matrix_blend_pixel: RGBA8 color matrix with blend toward mapped color
//
//   channel   dir   handshake           payload
//   s_*       in    s_tvalid/s_tready   s_tdata = red, green, blue, alpha
//   m_*       out   m_tvalid/m_tready   m_tdata = red, green, blue, alpha
//   apb       in    psel/penable        weights and blend strength, 4 regs
//
// One pixel per clock sustained while m_tready stays high; the datapath has five
// register stages (products, sums, divide by 255, blend product, step).
// Each stage has its own valid bit and advances when the next one is empty
// or moving, so a stall at m_tready fills bubbles before it backs up s_tready.
// Reset clears all valid bits and loads the identity matrix with zero blend.
// ----------------------------------------------------------------------------
module color_matrix_blend_pixel (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [31:0]                  s_tdata,   // in_red, in_green, in_blue, in_alpha
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata,   // out_red, out_green, out_blue, out_alpha
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cmb_pkg::ADDR_W-1:0]   paddr,
	input  logic [cmb_pkg::DATA_W-1:0]   pwdata,
	output logic [cmb_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	cmb_pkg::cfg_t cfg;
	cmb_pkg::map_t map;
	cmb_pkg::pix_t out_pix;
	logic          map_valid, map_ready;

	cmb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cmb_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_pix    (cmb_pkg::pix_t'(s_tdata)),
		.out_valid (map_valid),
		.out_ready (map_ready),
		.out_map   (map)
	);

	cmb_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (map_valid),
		.in_ready  (map_ready),
		.in_map    (map),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pix   (out_pix)
	);

	assign m_tdata = out_pix;

endmodule

[hw/rtl/cmb_checker.sv]
// ----------------------------------------------------------------------------
// cmb_checker: port-level checks for color_matrix_blend_pixel
// Output hold under stall, ready propagation, fixed latency and alpha path.
// ----------------------------------------------------------------------------
module cmb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an empty or draining output never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input blocked with output free");

	// with no stall a transferred pixel reaches the output once it has passed the full pipeline
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready ##1 m_tready
		##1 m_tready |=> m_tvalid)
		else $error("result missing after pipeline latency");

	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tready ##1 m_tready ##1 m_tready ##1 m_tready
		##1 m_tready |=> m_tdata[31:24] == $past(s_tdata[31:24], 5))
		else $error("alpha not passed through");

endmodule

bind color_matrix_blend_pixel cmb_checker u_cmb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
